### design/quadrant_swap_address_remap_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadrant swap address remap core
// Immediate-implication and next-cycle-implication property shorthands.
// ----------------------------------------------------------------------------
`ifndef QUADRANT_SWAP_ADDRESS_REMAP_CORE_MACROS_SVH
`define QUADRANT_SWAP_ADDRESS_REMAP_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define QSAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("qsar: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define QSAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("qsar: next-cycle check failed");

`endif

### design/qsar_pkg.sv
// ----------------------------------------------------------------------------
// qsar_pkg
// Shared widths, register codes, config bundle and quadrant helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qsar_pkg;

	localparam int PIX_W       = 12;
	localparam int CORNER_W    = 14;
	localparam int DIM_W       = 13;
	localparam int MODE_W      = 2;
	localparam int COORD_W     = CORNER_W + 1;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 14;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;
	localparam int MAX_DIM_DEF = 4096;
	localparam int DIM_RESET   = 4096;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [1:0] quad_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CORNER_A_X = 3'd0,
		REG_CORNER_A_Y = 3'd1,
		REG_CORNER_B_X = 3'd2,
		REG_CORNER_B_Y = 3'd3,
		REG_IMAGE_W    = 3'd4,
		REG_IMAGE_H    = 3'd5,
		REG_SWAP_MODE  = 3'd6
	} cfg_index_e;

	typedef enum logic [MODE_W-1:0] {
		SWAP_CW   = 2'd0,
		SWAP_ACW  = 2'd1,
		SWAP_DIAG = 2'd2
	} swap_mode_e;

	localparam quad_t Q_TL = 2'd0;
	localparam quad_t Q_TR = 2'd1;
	localparam quad_t Q_BL = 2'd2;
	localparam quad_t Q_BR = 2'd3;

	typedef struct packed {
		logic signed [CORNER_W-1:0] corner_a_x;
		logic signed [CORNER_W-1:0] corner_a_y;
		logic signed [CORNER_W-1:0] corner_b_x;
		logic signed [CORNER_W-1:0] corner_b_y;
		logic [DIM_W-1:0]           image_width;
		logic [DIM_W-1:0]           image_height;
		logic [MODE_W-1:0]          swap_mode;
	} cfg_t;

	function automatic coord_t clamp_coord(coord_t v, coord_t dim);
		coord_t r;
		if (v < 0) begin
			r = '0;
		end else if (v >= dim) begin
			r = dim - coord_t'(1);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// quadrant that destination quadrant dq reads from
	function automatic quad_t src_quad(logic [MODE_W-1:0] mode, quad_t dq);
		quad_t r;
		r = ~dq;
		if (mode == SWAP_CW) begin
			unique case (dq)
				Q_TL: r = Q_BL;
				Q_TR: r = Q_TL;
				Q_BL: r = Q_BR;
				default: r = Q_TR;
			endcase
		end else if (mode == SWAP_ACW) begin
			unique case (dq)
				Q_TL: r = Q_TR;
				Q_TR: r = Q_BR;
				Q_BL: r = Q_TL;
				default: r = Q_BL;
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/qsar_cfg_regs.sv
// ----------------------------------------------------------------------------
// qsar_cfg_regs
// Write-only configuration register file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsar_cfg_regs
	import qsar_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.corner_a_x   <= '0;
			cfg_q.corner_a_y   <= '0;
			cfg_q.corner_b_x   <= '0;
			cfg_q.corner_b_y   <= '0;
			cfg_q.image_width  <= DIM_W'(DIM_RESET);
			cfg_q.image_height <= DIM_W'(DIM_RESET);
			cfg_q.swap_mode    <= SWAP_CW;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CORNER_A_X: cfg_q.corner_a_x   <= cfg_data[CORNER_W-1:0];
				REG_CORNER_A_Y: cfg_q.corner_a_y   <= cfg_data[CORNER_W-1:0];
				REG_CORNER_B_X: cfg_q.corner_b_x   <= cfg_data[CORNER_W-1:0];
				REG_CORNER_B_Y: cfg_q.corner_b_y   <= cfg_data[CORNER_W-1:0];
				REG_IMAGE_W:    cfg_q.image_width  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_H:    cfg_q.image_height <= cfg_data[DIM_W-1:0];
				REG_SWAP_MODE:  cfg_q.swap_mode    <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### design/qsar_axis_bound.sv
// ----------------------------------------------------------------------------
// qsar_axis_bound
// One axis: limit image size, clamp both corners, trim the far corner odd.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsar_axis_bound
	import qsar_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic signed [CORNER_W-1:0] corner_a,
	input  wire logic signed [CORNER_W-1:0] corner_b,
	input  wire logic [DIM_W-1:0]           dim_raw,
	output coord_t                          lo,
	output coord_t                          hi
);

	localparam int DIM_CODE_MAX = (1 << DIM_W) - 1;
	localparam int DIM_CAP      = (MAX_DIM > DIM_CODE_MAX) ? DIM_CODE_MAX : MAX_DIM;
	localparam logic [DIM_W-1:0] DIM_CAP_C = DIM_W'(DIM_CAP);

	logic [DIM_W-1:0] dim;
	coord_t           dim_s;
	coord_t           a_c;
	coord_t           b_c;

	always_comb begin
		if (dim_raw == '0) begin
			dim = DIM_W'(1);
		end else if (dim_raw > DIM_CAP_C) begin
			dim = DIM_CAP_C;
		end else begin
			dim = dim_raw;
		end
	end

	assign dim_s = $signed({2'b00, dim});
	assign a_c   = clamp_coord($signed({corner_a[CORNER_W-1], corner_a}), dim_s);
	assign b_c   = clamp_coord($signed({corner_b[CORNER_W-1], corner_b}), dim_s);

	// span even when the corners share parity: pull the far corner back one
	assign lo = a_c;
	assign hi = (a_c[0] == b_c[0]) ? (b_c - coord_t'(1)) : b_c;

endmodule

`default_nettype wire

### design/qsar_axis_split.sv
// ----------------------------------------------------------------------------
// qsar_axis_split
// One axis: span check, quadrant midpoint, pixel range and half select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsar_axis_split
	import qsar_pkg::*;
(
	input  wire coord_t             lo,
	input  wire coord_t             hi,
	input  wire logic [PIX_W-1:0]   pix,
	output logic                    span_ok,
	output logic                    in_span,
	output logic                    upper,
	output coord_t                  mid
);

	coord_t                   span;
	coord_t                   pix_s;
	logic signed [COORD_W:0]  sum;

	assign span    = hi - lo;
	// span is odd here, so quadrant size >= 2 means span >= 3
	assign span_ok = (span >= coord_t'(3));

	// mid = lo + span/2 + 1 = (lo + hi + 1) / 2 for odd span
	assign sum = {lo[COORD_W-1], lo} + {hi[COORD_W-1], hi} + (COORD_W+1)'(1);
	assign mid = sum[COORD_W:1];

	assign pix_s   = $signed({{(COORD_W-PIX_W){1'b0}}, pix});
	assign in_span = (pix_s >= lo) && (pix_s <= hi);
	assign upper   = (pix_s >= mid);

endmodule

`default_nettype wire

### design/quadrant_swap_address_remap_core.sv
// ----------------------------------------------------------------------------
// quadrant_swap_address_remap_core
// Maps a destination pixel to the source pixel of a quadrant exchange.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             pixel_x, pixel_y
//   m_axis    out  tvalid/tready             source_x, source_y, in_area, area_ok
//   cfg       in   cfg_wr_en (no wait)       cfg_index, cfg_data
//
// One coordinate per clock while m_axis is not stalled; the s_axis transfer reaches
// m_axis through the input / bound / split / output registers.
// Reset clears all stage valids and loads register defaults.
// A stall on m_axis holds the output; the stages behind it keep filling and
// s_axis_tready drops only when all four are occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "quadrant_swap_address_remap_core_macros.svh"

module quadrant_swap_address_remap_core
	import qsar_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// [11:0] pixel_x, [23:12] pixel_y
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [11:0] source_x, [23:12] source_y, [24] in_area, [25] area_ok, rest zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	cfg_t cfg;

	qsar_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4 = !valid_s4 || m_axis_tready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_axis_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: input register
	logic [PIX_W-1:0] px_s1, py_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1 <= s_axis_tdata[PIX_W-1:0];
			py_s1 <= s_axis_tdata[2*PIX_W-1:PIX_W];
		end
	end

	// stage 1 -> 2: clamp and trim the area
	coord_t lo_x, hi_x, lo_y, hi_y;

	qsar_axis_bound #(.MAX_DIM(MAX_DIM)) u_bound_x (
		.corner_a (cfg.corner_a_x),
		.corner_b (cfg.corner_b_x),
		.dim_raw  (cfg.image_width),
		.lo       (lo_x),
		.hi       (hi_x)
	);

	qsar_axis_bound #(.MAX_DIM(MAX_DIM)) u_bound_y (
		.corner_a (cfg.corner_a_y),
		.corner_b (cfg.corner_b_y),
		.dim_raw  (cfg.image_height),
		.lo       (lo_y),
		.hi       (hi_y)
	);

	logic [PIX_W-1:0] px_s2, py_s2;
	coord_t           lo_x_s2, hi_x_s2, lo_y_s2, hi_y_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			lo_x_s2 <= lo_x;
			hi_x_s2 <= hi_x;
			lo_y_s2 <= lo_y;
			hi_y_s2 <= hi_y;
		end
	end

	// stage 2 -> 3: quadrant split and containment
	logic   ok_x, ok_y, in_x, in_y, up_x, up_y;
	coord_t mid_x, mid_y;

	qsar_axis_split u_split_x (
		.lo      (lo_x_s2),
		.hi      (hi_x_s2),
		.pix     (px_s2),
		.span_ok (ok_x),
		.in_span (in_x),
		.upper   (up_x),
		.mid     (mid_x)
	);

	qsar_axis_split u_split_y (
		.lo      (lo_y_s2),
		.hi      (hi_y_s2),
		.pix     (py_s2),
		.span_ok (ok_y),
		.in_span (in_y),
		.upper   (up_y),
		.mid     (mid_y)
	);

	logic [PIX_W-1:0] px_s3, py_s3;
	coord_t           lo_x_s3, mid_x_s3, lo_y_s3, mid_y_s3;
	quad_t            dq_s3;
	logic             ok_s3, inside_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			px_s3     <= px_s2;
			py_s3     <= py_s2;
			lo_x_s3   <= lo_x_s2;
			mid_x_s3  <= mid_x;
			lo_y_s3   <= lo_y_s2;
			mid_y_s3  <= mid_y;
			dq_s3     <= {up_y, up_x};
			ok_s3     <= ok_x && ok_y;
			inside_s3 <= ok_x && ok_y && in_x && in_y;
		end
	end

	// stage 3 -> 4: swap quadrant and rebase offsets
	quad_t  sq;
	coord_t base_x, base_y, org_x, org_y, sx_full, sy_full;

	assign sq     = src_quad(cfg.swap_mode, dq_s3);
	assign base_x = dq_s3[0] ? mid_x_s3 : lo_x_s3;
	assign base_y = dq_s3[1] ? mid_y_s3 : lo_y_s3;
	assign org_x  = sq[0] ? mid_x_s3 : lo_x_s3;
	assign org_y  = sq[1] ? mid_y_s3 : lo_y_s3;
	assign sx_full = $signed({{(COORD_W-PIX_W){1'b0}}, px_s3}) - base_x + org_x;
	assign sy_full = $signed({{(COORD_W-PIX_W){1'b0}}, py_s3}) - base_y + org_y;

	logic [PIX_W-1:0] sx_s4, sy_s4;
	logic             in_area_s4, area_ok_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sx_s4      <= inside_s3 ? sx_full[PIX_W-1:0] : px_s3;
			sy_s4      <= inside_s3 ? sy_full[PIX_W-1:0] : py_s3;
			in_area_s4 <= inside_s3;
			area_ok_s4 <= ok_s3;
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {{(OUT_TDATA_W-2*PIX_W-2){1'b0}}, area_ok_s4, in_area_s4, sy_s4, sx_s4};

	// checks
	`QSAR_ASSERT_IMP(a_inside_needs_ok, clk, arst_n, valid_s4 && in_area_s4, area_ok_s4)
	`QSAR_ASSERT_IMP(a_backpressure_full, clk, arst_n, !s_axis_tready,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_axis_tready)
	`QSAR_ASSERT_NXT(a_transfer_lands, clk, arst_n, s_axis_tvalid && s_axis_tready, valid_s1)

endmodule

`default_nettype wire
